### rtl/fbdcu_pkg.sv
package fbdcu_pkg;

    // Stream widths (whole bytes)
    localparam int IN_W  = 160;
    localparam int OUT_W = 120;

    // Disk geometry
    localparam int BLOCK_BYTES = 512;
    localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);
    localparam int POS_W       = 41;
    localparam int XB_W        = 25;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ENABLED = 1'b1;
    localparam logic [31:0] TOTAL_BLOCKS_RST = 32'd65536;

    // Channel command codes
    localparam logic [7:0] OP_BOOT_READ  = 8'h02;
    localparam logic [7:0] OP_NOP        = 8'h03;
    localparam logic [7:0] OP_SENSE      = 8'h04;
    localparam logic [7:0] OP_UNCOND_RSV = 8'h14;
    localparam logic [7:0] OP_WRITE      = 8'h41;
    localparam logic [7:0] OP_READ       = 8'h42;
    localparam logic [7:0] OP_LOCATE     = 8'h43;
    localparam logic [7:0] OP_DEF_EXTENT = 8'h63;
    localparam logic [7:0] OP_READ_CHARS = 8'h64;
    localparam logic [7:0] OP_RELEASE    = 8'h94;
    localparam logic [7:0] OP_READ_LOG   = 8'hA4;
    localparam logic [7:0] OP_RESERVE    = 8'hB4;
    localparam logic [7:0] OP_SENSE_ID   = 8'hE4;

    // Locate operation codes (low nibble)
    localparam logic [3:0] LOC_WRITE      = 4'h1;
    localparam logic [3:0] LOC_READ_REPL  = 4'h2;
    localparam logic [3:0] LOC_FORMAT     = 4'h4;
    localparam logic [3:0] LOC_WRITE_VFY  = 4'h5;
    localparam logic [3:0] LOC_READ       = 4'h6;

    // Result status
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_XFER     = 3'd1;
    localparam logic [2:0] ST_XFER_OVR = 3'd2;
    localparam logic [2:0] ST_REJECT   = 3'd3;
    localparam logic [2:0] ST_OVERRUN  = 3'd4;
    localparam logic [2:0] ST_EQCHECK  = 3'd5;

    // Sense codes
    localparam logic [7:0] SNS_REJECT  = 8'h80;
    localparam logic [7:0] SNS_EQUIP   = 8'h10;
    localparam logic [7:0] SNS_OVERRUN = 8'h04;

    // Response kinds
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_SENSE = 3'd1;
    localparam logic [2:0] KIND_CHARS = 3'd2;
    localparam logic [2:0] KIND_ID    = 3'd3;
    localparam logic [2:0] KIND_LOG   = 3'd4;

    // Remainder unit for the locate replication check
    localparam int DIV_STEPS = 8;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture request, seed remainder unit
        logic div_step;  // one remainder step
        logic commit;    // update state, load result register
    } cmd_t;

endpackage

### rtl/fbdcu_ctrl.sv
module fbdcu_ctrl
    import fbdcu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 valid_reg, valid_next;
    logic                 out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

    // Sequence: capture, remainder steps, execute when result slot frees
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the result until taken
    always_comb begin
        valid_next = valid_reg;
        if (cmd.commit) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

### rtl/fbdcu_dp.sv
module fbdcu_dp
    import fbdcu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    input  logic [IN_W-1:0]      s_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    output logic [OUT_W-1:0]     m_tdata
);

    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       sense;
        logic             set_sense;
        logic [15:0]      resid;
        logic             il;
        logic [POS_W-1:0] offset;
        logic [XB_W-1:0]  xbytes;
        logic [15:0]      cbytes;
        logic             isread;
        logic             xfer;
        logic [15:0]      bl_new;
        logic [POS_W-1:0] pos_new;
    } sio_t;

    typedef struct packed {
        logic [15:0] resid;
        logic        il;
        logic [5:0]  rlen;
    } resp_t;

    function automatic logic length_flag(input logic [XB_W-1:0] cnt,
                                         input logic [XB_W-1:0] moved,
                                         input logic [XB_W-1:0] avail,
                                         input logic dc, input logic sli);
        logic suppress;
        logic goes_on;
        suppress = sli && !dc;
        goes_on  = dc && (moved < avail);
        return !suppress && !goes_on && (cnt != avail);
    endfunction

    function automatic resp_t respond(input logic [5:0] avail, input logic [15:0] cnt,
                                      input logic dc, input logic sli);
        resp_t r;
        logic [15:0] len;
        len    = (cnt < 16'(avail)) ? cnt : 16'(avail);
        r.resid = cnt - len;
        r.il    = length_flag(XB_W'(cnt), XB_W'(len), XB_W'(avail), dc, sli);
        r.rlen  = len[5:0];
        return r;
    endfunction

    function automatic sio_t start_io(input logic rd, input logic [15:0] cnt,
                                      input logic dc, input logic sli, input logic we,
                                      input logic [15:0] bl, input logic [POS_W-1:0] pos);
        sio_t r;
        logic [XB_W-1:0] max_b;
        logic [15:0]     guest;
        logic            ovr;
        logic [15:0]     g2;
        logic [15:0]     blocks;
        logic [XB_W-1:0] io;
        max_b = {bl, {BLK_SHIFT{1'b0}}};
        guest = (XB_W'(cnt) < max_b) ? cnt : max_b[15:0];
        ovr   = dc && (guest[BLK_SHIFT-1:0] != '0);
        g2    = ovr ? {guest[15:BLK_SHIFT], {BLK_SHIFT{1'b0}}} : guest;
        if (!rd && g2 == '0 && !dc) begin
            blocks = bl;
        end else begin
            blocks = 16'(g2[15:BLK_SHIFT]) + 16'(|g2[BLK_SHIFT-1:0]);
        end
        io = rd ? XB_W'(g2) : {blocks, {BLK_SHIFT{1'b0}}};
        r         = '0;
        r.bl_new  = bl;
        r.pos_new = pos;
        if (!rd && !we) begin
            r.status    = ST_EQCHECK;
            r.sense     = SNS_EQUIP;
            r.set_sense = 1'b1;
            r.resid     = cnt;
        end else begin
            r.resid = cnt - g2;
            r.il    = ovr ? 1'b0 : length_flag(XB_W'(cnt), XB_W'(g2), max_b, dc, sli);
            if (io == '0) begin
                if (ovr) begin
                    r.status    = ST_OVERRUN;
                    r.sense     = SNS_OVERRUN;
                    r.set_sense = 1'b1;
                end else begin
                    r.status = ST_DONE;
                end
            end else begin
                r.offset  = pos;
                r.xbytes  = io;
                r.cbytes  = g2;
                r.isread  = rd;
                r.xfer    = 1'b1;
                r.bl_new  = bl - blocks;
                r.pos_new = pos + POS_W'(io);
                if (ovr) begin
                    r.status    = ST_XFER_OVR;
                    r.sense     = SNS_OVERRUN;
                    r.set_sense = 1'b1;
                end else begin
                    r.status = ST_XFER;
                end
            end
        end
        return r;
    endfunction

    // Captured request
    logic [7:0]  opc_reg;
    logic        first_reg, dc_reg, sli_reg;
    logic [15:0] count_reg;
    logic [31:0] pw0_reg, pw1_reg, pw2_reg, pw3_reg;

    // Configuration
    logic [31:0] total_reg;
    logic        we_reg;

    // Unit state
    logic             ev_reg, ev_next;
    logic [7:0]       wmask_reg, wmask_next;
    logic [31:0]      ebase_reg, ebase_next;
    logic [31:0]      elow_reg, elow_next;
    logic [31:0]      ehigh_reg, ehigh_next;
    logic [7:0]       lop_reg, lop_next;
    logic [15:0]      bl_reg, bl_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             boot_reg, boot_next;
    logic             rsv_reg, rsv_next;
    logic [7:0]       prev_reg, prev_next;
    logic             pchain_reg, pchain_next;
    logic [7:0]       sense_reg, sense_next;

    // Remainder unit
    logic [15:0] rem_reg;
    logic [7:0]  quo_reg;
    logic [16:0] rem_trial;

    // Result register fields
    logic [2:0]       r_status, o_status_reg;
    logic [7:0]       r_sense, o_sense_reg;
    logic [15:0]      r_resid, o_resid_reg;
    logic             r_il, o_il_reg;
    logic [POS_W-1:0] r_offset, o_offset_reg;
    logic [XB_W-1:0]  r_xbytes, o_xbytes_reg;
    logic [15:0]      r_cbytes, o_cbytes_reg;
    logic             r_isread, o_isread_reg;
    logic [2:0]       r_kind, o_kind_reg;
    logic [5:0]       r_rlen, o_rlen_reg;

    // Decode helpers
    logic [7:0]  prev;
    logic        cont, after_boot, ev0;
    logic [3:0]  cur_loc;
    logic        io_rd;
    logic [15:0] io_bl;
    logic [POS_W-1:0] io_pos;
    sio_t        sio;
    resp_t       rsp;
    logic [5:0]  rsp_avail;
    logic [2:0]  rsp_kind;

    // Locate and define extent checks
    logic [7:0]  l_op, l_repl;
    logic [15:0] l_nblk;
    logic [31:0] l_first, l_sum;
    logic [1:0]  l_wm;
    logic        l_bad_op, l_bad;
    logic        d_bad;

    assign rem_trial = {rem_reg, quo_reg[7]};

    // Remainder step: shift in one dividend bit, subtract when it fits
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg <= '0;
            quo_reg <= s_tdata[50:43];
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[6:0], 1'b0};
            if (rem_trial >= {1'b0, pw0_reg[15:0]}) begin
                rem_reg <= 16'(rem_trial - {1'b0, pw0_reg[15:0]});
            end else begin
                rem_reg <= rem_trial[15:0];
            end
        end
    end

    // Capture the request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            opc_reg   <= s_tdata[7:0];
            first_reg <= s_tdata[8];
            dc_reg    <= s_tdata[9];
            sli_reg   <= s_tdata[10];
            count_reg <= s_tdata[26:11];
            pw0_reg   <= s_tdata[58:27];
            pw1_reg   <= s_tdata[90:59];
            pw2_reg   <= s_tdata[122:91];
            pw3_reg   <= s_tdata[154:123];
        end
    end

    assign prev       = first_reg ? 8'h00 : prev_reg;
    assign cont       = !first_reg && pchain_reg;
    assign after_boot = first_reg && boot_reg && (opc_reg == OP_READ);
    assign ev0        = (first_reg && !after_boot) ? 1'b0 : ev_reg;
    assign cur_loc    = lop_reg[3:0];

    // One shared transfer computation
    assign io_rd  = (opc_reg != OP_WRITE);
    assign io_bl  = (opc_reg == OP_BOOT_READ) ? 16'd1 : bl_reg;
    assign io_pos = (opc_reg == OP_BOOT_READ) ? '0 : pos_reg;
    assign sio    = start_io(io_rd, count_reg, dc_reg, sli_reg, we_reg, io_bl, io_pos);

    // One shared fixed response computation
    always_comb begin
        case (opc_reg)
            OP_READ_CHARS: begin rsp_avail = 6'd32; rsp_kind = KIND_CHARS; end
            OP_SENSE_ID:   begin rsp_avail = 6'd7;  rsp_kind = KIND_ID;    end
            OP_READ_LOG:   begin rsp_avail = 6'd24; rsp_kind = KIND_LOG;   end
            default:       begin rsp_avail = 6'd24; rsp_kind = KIND_SENSE; end
        endcase
    end
    assign rsp = respond(rsp_avail, count_reg, dc_reg, sli_reg);

    // Locate parameter checks
    assign l_op    = pw0_reg[31:24];
    assign l_repl  = pw0_reg[23:16];
    assign l_nblk  = pw0_reg[15:0];
    assign l_first = pw1_reg;
    assign l_wm    = wmask_reg[7:6];
    assign l_sum   = ebase_reg + l_first - elow_reg;

    always_comb begin
        if (l_op[7:5] != 3'b000) begin
            l_bad_op = 1'b1;
        end else begin
            case (l_op[3:0])
                LOC_WRITE, LOC_WRITE_VFY: l_bad_op = (l_wm == 2'd1);
                LOC_READ:                 l_bad_op = 1'b0;
                LOC_READ_REPL: l_bad_op = (l_repl == '0) || (l_nblk == '0) || (rem_reg != '0);
                LOC_FORMAT:               l_bad_op = (l_wm == 2'd0);
                default:                  l_bad_op = 1'b1;
            endcase
        end
    end

    assign l_bad = l_bad_op || (l_nblk == '0) || (l_first < elow_reg) ||
                   (l_first > ehigh_reg) ||
                   (33'(l_nblk) > ({1'b0, ehigh_reg} - {1'b0, l_first} + 33'd1));

    // Define extent parameter checks
    assign d_bad = pw0_reg[29] || (pw3_reg < pw2_reg) || (pw1_reg >= total_reg) ||
                   ((pw3_reg - pw2_reg) >= (total_reg - pw1_reg));

    // Execute the command
    always_comb begin
        ev_next     = ev_reg;
        wmask_next  = wmask_reg;
        ebase_next  = ebase_reg;
        elow_next   = elow_reg;
        ehigh_next  = ehigh_reg;
        lop_next    = lop_reg;
        bl_next     = bl_reg;
        pos_next    = pos_reg;
        boot_next   = first_reg ? 1'b0 : boot_reg;
        rsv_next    = rsv_reg;
        prev_next   = opc_reg;
        pchain_next = dc_reg;
        sense_next  = sense_reg;
        r_status    = ST_DONE;
        r_sense     = '0;
        r_resid     = '0;
        r_il        = 1'b0;
        r_offset    = '0;
        r_xbytes    = '0;
        r_cbytes    = '0;
        r_isread    = 1'b0;
        r_kind      = KIND_NONE;
        r_rlen      = '0;
        if (first_reg && !after_boot) begin
            ev_next = 1'b0;
        end
        case (opc_reg)
            OP_BOOT_READ: begin
                if (!first_reg && prev != OP_BOOT_READ) begin
                    r_status = ST_REJECT; r_sense = SNS_REJECT; r_resid = count_reg;
                    sense_next = SNS_REJECT;
                end else if (dc_reg) begin
                    r_status = ST_OVERRUN; r_sense = SNS_OVERRUN; r_resid = count_reg;
                    sense_next = SNS_OVERRUN;
                end else begin
                    wmask_next = '0;
                    ebase_next = '0;
                    elow_next  = '0;
                    ehigh_next = total_reg - 32'd1;
                    ev_next    = 1'b1;
                    bl_next    = 16'd1;
                    pos_next   = sio.pos_new;
                    r_status = sio.status; r_sense = sio.sense; r_resid = sio.resid;
                    r_il = sio.il; r_offset = sio.offset; r_xbytes = sio.xbytes;
                    r_cbytes = sio.cbytes; r_isread = sio.isread;
                    if (sio.set_sense) sense_next = sio.sense;
                    if (sio.xfer) boot_next = 1'b1;
                end
            end
            OP_NOP: begin
                r_resid = count_reg;
            end
            OP_WRITE, OP_READ: begin
                if ((opc_reg == OP_WRITE &&
                     ((prev != OP_LOCATE && !(cont && prev == OP_WRITE)) ||
                      (cur_loc != LOC_WRITE && cur_loc != LOC_WRITE_VFY))) ||
                    (opc_reg == OP_READ &&
                     ((!after_boot && prev != OP_LOCATE && prev != OP_BOOT_READ &&
                       !(cont && prev == OP_READ)) ||
                      (!after_boot && prev != OP_BOOT_READ &&
                       cur_loc != LOC_READ && cur_loc != LOC_READ_REPL)))) begin
                    r_status = ST_REJECT; r_sense = SNS_REJECT; r_resid = count_reg;
                    sense_next = SNS_REJECT;
                end else begin
                    bl_next  = sio.bl_new;
                    pos_next = sio.pos_new;
                    r_status = sio.status; r_sense = sio.sense; r_resid = sio.resid;
                    r_il = sio.il; r_offset = sio.offset; r_xbytes = sio.xbytes;
                    r_cbytes = sio.cbytes; r_isread = sio.isread;
                    if (sio.set_sense) sense_next = sio.sense;
                end
            end
            OP_LOCATE: begin
                if (count_reg < 16'd8 || !ev0) begin
                    r_status = ST_REJECT; r_sense = SNS_REJECT; r_resid = count_reg;
                    sense_next = SNS_REJECT;
                end else if (l_bad) begin
                    r_status = ST_REJECT; r_sense = SNS_REJECT;
                    r_resid = count_reg - 16'd8;
                    sense_next = SNS_REJECT;
                end else begin
                    lop_next = l_op;
                    bl_next  = l_nblk;
                    pos_next = {l_sum, {BLK_SHIFT{1'b0}}};
                    r_resid  = count_reg - 16'd8;
                end
            end
            OP_DEF_EXTENT: begin
                if (count_reg < 16'd16 || ev0) begin
                    r_status = ST_REJECT; r_sense = SNS_REJECT; r_resid = count_reg;
                    sense_next = SNS_REJECT;
                end else if (d_bad) begin
                    r_status = ST_REJECT; r_sense = SNS_REJECT;
                    r_resid = count_reg - 16'd16;
                    sense_next = SNS_REJECT;
                end else begin
                    wmask_next = pw0_reg[31:24];
                    ebase_next = pw1_reg;
                    elow_next  = pw2_reg;
                    ehigh_next = pw3_reg;
                    ev_next    = 1'b1;
                    r_resid    = count_reg - 16'd16;
                end
            end
            OP_READ_CHARS, OP_SENSE_ID, OP_READ_LOG: begin
                r_resid = rsp.resid; r_il = rsp.il; r_kind = rsp_kind; r_rlen = rsp.rlen;
            end
            OP_RELEASE, OP_RESERVE, OP_SENSE, OP_UNCOND_RSV: begin
                if (((opc_reg == OP_RELEASE || opc_reg == OP_RESERVE) && ev0) ||
                    (opc_reg == OP_UNCOND_RSV && !first_reg)) begin
                    r_status = ST_REJECT; r_sense = SNS_REJECT; r_resid = count_reg;
                    sense_next = SNS_REJECT;
                end else begin
                    if (opc_reg == OP_RELEASE) rsv_next = 1'b0;
                    if (opc_reg == OP_RESERVE || opc_reg == OP_UNCOND_RSV) rsv_next = 1'b1;
                    r_sense    = sense_reg;
                    sense_next = '0;
                    r_resid = rsp.resid; r_il = rsp.il; r_kind = rsp_kind; r_rlen = rsp.rlen;
                end
            end
            default: begin
                r_status = ST_REJECT; r_sense = SNS_REJECT; r_resid = count_reg;
                sense_next = SNS_REJECT;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= TOTAL_BLOCKS_RST;
            we_reg    <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TOTAL_BLOCKS:  total_reg <= cfg_wdata;
                CFG_WRITE_ENABLED: we_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Advance the unit state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_reg     <= 1'b0;
            wmask_reg  <= '0;
            ebase_reg  <= '0;
            elow_reg   <= '0;
            ehigh_reg  <= '0;
            lop_reg    <= '0;
            bl_reg     <= '0;
            pos_reg    <= '0;
            boot_reg   <= 1'b0;
            rsv_reg    <= 1'b0;
            prev_reg   <= '0;
            pchain_reg <= 1'b0;
            sense_reg  <= '0;
        end else if (cmd.commit) begin
            ev_reg     <= ev_next;
            wmask_reg  <= wmask_next;
            ebase_reg  <= ebase_next;
            elow_reg   <= elow_next;
            ehigh_reg  <= ehigh_next;
            lop_reg    <= lop_next;
            bl_reg     <= bl_next;
            pos_reg    <= pos_next;
            boot_reg   <= boot_next;
            rsv_reg    <= rsv_next;
            prev_reg   <= prev_next;
            pchain_reg <= pchain_next;
            sense_reg  <= sense_next;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            o_status_reg <= r_status;
            o_sense_reg  <= r_sense;
            o_resid_reg  <= r_resid;
            o_il_reg     <= r_il;
            o_offset_reg <= r_offset;
            o_xbytes_reg <= r_xbytes;
            o_cbytes_reg <= r_cbytes;
            o_isread_reg <= r_isread;
            o_kind_reg   <= r_kind;
            o_rlen_reg   <= r_rlen;
        end
    end

    assign m_tdata = {o_rlen_reg, o_kind_reg, o_isread_reg, o_cbytes_reg, o_xbytes_reg,
                      o_offset_reg, o_il_reg, o_resid_reg, o_sense_reg, o_status_reg};

endmodule

### rtl/fixed_block_disk_command_unit.sv
// Fixed-block disk command unit: takes one channel command per request and
// returns one result. The request is captured, runs through 8 steps of the
// bit-serial remainder unit used by the locate replication check and is then
// executed, which loads the result. The next command is accepted the cycle
// after the result is loaded, while that result may still wait on m_tready.
// A command that is ready to execute while the previous result still waits
// holds until that result is taken. No clearing pass is needed after reset.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while the unit is idle, the block does not enforce it.
module fixed_block_disk_command_unit
    import fbdcu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // operation, first_in_program, data_chain, suppress_length, byte_count,
    // param_word0, param_word1, param_word2, param_word3
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status, sense_out, residual_count, incorrect_length, xfer_offset,
    // xfer_bytes, channel_bytes, xfer_is_read, response_kind, response_length
    output logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata
);

    cmd_t cmd;

    fbdcu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fbdcu_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

endmodule

### rtl/fbdcu_checker.sv
module fbdcu_checker
    import fbdcu_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_W-1:0]     m_tdata
);

    // Drop the result after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A reject always carries the reject sense code
    a_reject_sense: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == ST_REJECT |-> m_tdata[10:3] == SNS_REJECT)
        else $error("reject without reject sense");

    // Transfer fields are zero unless a transfer happened
    a_no_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ST_XFER && m_tdata[2:0] != ST_XFER_OVR
        |-> m_tdata[110:28] == '0)
        else $error("transfer fields set without transfer");

    // No new request while a command is being worked on
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted during execution");

endmodule

bind fixed_block_disk_command_unit fbdcu_checker u_fbdcu_checker (.*);

### tb/tb.sv
module tb;
    import fbdcu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // One channel command word, first field in the low bits
    typedef struct packed {
        logic [31:0] pw3;
        logic [31:0] pw2;
        logic [31:0] pw1;
        logic [31:0] pw0;
        logic [15:0] count;
        logic        sli;
        logic        dc;
        logic        first;
        logic [7:0]  opc;
    } ccw_t;

    // One command result, first field in the low bits
    typedef struct packed {
        logic [5:0]  rlen;
        logic [2:0]  kind;
        logic        is_read;
        logic [15:0] cbytes;
        logic [24:0] xbytes;
        logic [40:0] offset;
        logic        il;
        logic [15:0] resid;
        logic [7:0]  sense;
        logic [2:0]  status;
    } rsp_t;

    typedef struct {
        ccw_t cmd;
        bit   typed;
        rsp_t want;
    } row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]        cfg_wdata = '0;

    always #6 aclk = ~aclk;

    fixed_block_disk_command_unit dut (.*);

    // Mirror of the command unit state
    logic [31:0] m_total = TOTAL_BLOCKS_RST;
    logic        m_wen = 1'b1;
    logic        ext_valid = 0;
    logic [7:0]  ext_mask = 0;
    logic [31:0] ext_base = 0, ext_low = 0, ext_high = 0;
    logic [7:0]  loc_op = 0;
    logic [15:0] blk_left = 0;
    logic [40:0] disk_pos = 0;
    logic        boot_pos = 0, reserved = 0;
    logic [7:0]  prev_cmd = 0;
    logic        prev_dc = 0;
    logic [7:0]  sense_byte = 0;
    rsp_t        pr;

    rsp_t pending_rsp[$];
    int   errors = 0;
    int   sent = 0;
    int   burst_left = 0;

    function automatic void unit_check(logic [7:0] code, logic [2:0] st, logic [31:0] resid);
        sense_byte = code;
        pr.status = st;
        pr.sense = code;
        pr.resid = resid[15:0];
        pr.il = 0;
    endfunction

    function automatic logic len_flag(logic [31:0] count, logic [31:0] moved,
                                      logic [31:0] avail, logic dc, logic sli);
        return !(sli && !dc) && !(dc && moved < avail) && count != avail;
    endfunction

    function automatic void respond(logic [2:0] kind, logic [31:0] avail,
                                    logic [31:0] count, logic dc, logic sli);
        logic [31:0] n;
        n = count < avail ? count : avail;
        pr.status = ST_DONE;
        pr.resid = 16'(count - n);
        pr.il = len_flag(count, n, avail, dc, sli);
        pr.kind = kind;
        pr.rlen = n[5:0];
    endfunction

    function automatic void sense_reply(logic [31:0] count, logic dc, logic sli);
        pr.sense = sense_byte;
        sense_byte = 0;
        respond(KIND_SENSE, 24, count, dc, sli);
    endfunction

    // Model a disk transfer that completes at once
    function automatic bit disk_io(bit rd, logic [31:0] count, logic dc, logic sli);
        logic [31:0] max_b, guest, blocks, io;
        bit ovr;
        max_b = 32'(blk_left) * BLOCK_BYTES;
        guest = count < max_b ? count : max_b;
        if (!rd && !m_wen) begin
            unit_check(SNS_EQUIP, ST_EQCHECK, count);
            return 0;
        end
        ovr = dc && (guest % BLOCK_BYTES) != 0;
        if (ovr) guest = guest - guest % BLOCK_BYTES;
        if (!rd && guest == 0 && !dc) blocks = 32'(blk_left);
        else blocks = (guest + BLOCK_BYTES - 1) / BLOCK_BYTES;
        io = rd ? guest : blocks * BLOCK_BYTES;
        pr.resid = 16'(count - guest);
        if (!ovr) pr.il = len_flag(count, guest, max_b, dc, sli);
        if (io == 0) begin
            if (ovr) unit_check(SNS_OVERRUN, ST_OVERRUN, count - guest);
            else pr.status = ST_DONE;
            return 0;
        end
        pr.offset = disk_pos;
        pr.xbytes = io[24:0];
        pr.cbytes = guest[15:0];
        pr.is_read = rd;
        blk_left = blk_left - blocks[15:0];
        disk_pos = disk_pos + 41'(rd ? guest : io);
        if (ovr) begin
            sense_byte = SNS_OVERRUN;
            pr.sense = SNS_OVERRUN;
            pr.status = ST_XFER_OVR;
        end else begin
            pr.status = ST_XFER;
        end
        return 1;
    endfunction

    function automatic void locate(ccw_t c);
        logic [7:0]  op;
        logic [7:0]  repl;
        logic [15:0] nblk;
        logic [31:0] fb, cnt;
        logic [1:0]  wm;
        bit bad;
        op = c.pw0[31:24];
        repl = c.pw0[23:16];
        nblk = c.pw0[15:0];
        fb = c.pw1;
        cnt = 32'(c.count);
        wm = ext_mask[7:6];
        bad = 0;
        if (cnt < 8 || !ext_valid) begin
            unit_check(SNS_REJECT, ST_REJECT, cnt);
            return;
        end
        if (op & 8'hE0) bad = 1;
        else case (op[3:0])
            LOC_WRITE, LOC_WRITE_VFY: bad = (wm == 1);
            LOC_READ: bad = 0;
            LOC_READ_REPL: bad = (repl == 0 || nblk == 0 || (16'(repl) % nblk) != 0);
            LOC_FORMAT: bad = (wm == 0);
            default: bad = 1;
        endcase
        if (!bad)
            bad = nblk == 0 || fb < ext_low || fb > ext_high ||
                  64'(nblk) > 64'(ext_high) - 64'(fb) + 1;
        if (bad) begin
            unit_check(SNS_REJECT, ST_REJECT, cnt - 8);
            return;
        end
        loc_op = op;
        blk_left = nblk;
        disk_pos = 41'((64'(ext_base) + 64'(fb) - 64'(ext_low)) * BLOCK_BYTES);
        pr.status = ST_DONE;
        pr.resid = 16'(cnt - 8);
    endfunction

    function automatic void define_extent(ccw_t c);
        logic [31:0] cnt;
        cnt = 32'(c.count);
        if (cnt < 16 || ext_valid) begin
            unit_check(SNS_REJECT, ST_REJECT, cnt);
            return;
        end
        if (c.pw0[29] || c.pw3 < c.pw2 || c.pw1 >= m_total ||
            64'(c.pw3) - 64'(c.pw2) >= 64'(m_total - c.pw1)) begin
            unit_check(SNS_REJECT, ST_REJECT, cnt - 16);
            return;
        end
        ext_mask = c.pw0[31:24];
        ext_base = c.pw1;
        ext_low = c.pw2;
        ext_high = c.pw3;
        ext_valid = 1;
        pr.status = ST_DONE;
        pr.resid = 16'(cnt - 16);
    endfunction

    // Work out the result of one command and advance the mirror state
    function automatic rsp_t predict_command(ccw_t c);
        logic [7:0]  prev;
        logic [31:0] cnt;
        logic [3:0]  op;
        bit cont, after_boot;
        prev = c.first ? 8'h00 : prev_cmd;
        cont = !c.first && prev_dc;
        after_boot = 0;
        op = loc_op[3:0];
        cnt = 32'(c.count);
        pr = '0;
        if (c.first) begin
            after_boot = boot_pos && c.opc == OP_READ;
            boot_pos = 0;
            if (!after_boot) ext_valid = 0;
        end
        case (c.opc)
            OP_BOOT_READ: begin
                if (!c.first && prev != OP_BOOT_READ) unit_check(SNS_REJECT, ST_REJECT, cnt);
                else if (c.dc) unit_check(SNS_OVERRUN, ST_OVERRUN, cnt);
                else begin
                    ext_mask = 0; ext_base = 0; ext_low = 0;
                    ext_high = m_total - 1;
                    ext_valid = 1;
                    blk_left = 1;
                    disk_pos = 0;
                    if (disk_io(1, cnt, c.dc, c.sli)) begin
                        blk_left = 1;
                        boot_pos = 1;
                    end
                end
            end
            OP_NOP: pr.resid = c.count;
            OP_WRITE: begin
                if ((prev != OP_LOCATE && !(cont && prev == OP_WRITE)) ||
                    (op != LOC_WRITE && op != LOC_WRITE_VFY))
                    unit_check(SNS_REJECT, ST_REJECT, cnt);
                else void'(disk_io(0, cnt, c.dc, c.sli));
            end
            OP_READ: begin
                if ((!after_boot && prev != OP_LOCATE && prev != OP_BOOT_READ &&
                     !(cont && prev == OP_READ)) ||
                    (!after_boot && prev != OP_BOOT_READ && op != LOC_READ &&
                     op != LOC_READ_REPL))
                    unit_check(SNS_REJECT, ST_REJECT, cnt);
                else void'(disk_io(1, cnt, c.dc, c.sli));
            end
            OP_LOCATE: locate(c);
            OP_DEF_EXTENT: define_extent(c);
            OP_READ_CHARS: respond(KIND_CHARS, 32, cnt, c.dc, c.sli);
            OP_RELEASE, OP_RESERVE: begin
                if (ext_valid) unit_check(SNS_REJECT, ST_REJECT, cnt);
                else begin
                    reserved = (c.opc == OP_RESERVE);
                    sense_reply(cnt, c.dc, c.sli);
                end
            end
            OP_SENSE: sense_reply(cnt, c.dc, c.sli);
            OP_UNCOND_RSV: begin
                if (!c.first) unit_check(SNS_REJECT, ST_REJECT, cnt);
                else begin
                    reserved = 1;
                    sense_reply(cnt, c.dc, c.sli);
                end
            end
            OP_SENSE_ID: respond(KIND_ID, 7, cnt, c.dc, c.sli);
            OP_READ_LOG: respond(KIND_LOG, 24, cnt, c.dc, c.sli);
            default: unit_check(SNS_REJECT, ST_REJECT, cnt);
        endcase
        prev_cmd = c.opc;
        prev_dc = c.dc;
        return pr;
    endfunction

    function automatic ccw_t mk(logic [7:0] opc, bit first, bit dc, bit sli,
                                logic [15:0] count, logic [31:0] p0 = 0,
                                logic [31:0] p1 = 0, logic [31:0] p2 = 0,
                                logic [31:0] p3 = 0);
        ccw_t c;
        c.opc = opc; c.first = first; c.dc = dc; c.sli = sli; c.count = count;
        c.pw0 = p0; c.pw1 = p1; c.pw2 = p2; c.pw3 = p3;
        return c;
    endfunction

    // Drive one request in bursts with random gaps; record its result on acceptance
    task automatic send(ccw_t c, bit typed = 0, rsp_t want = '0);
        rsp_t exp_rsp;
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, c};
        do @(posedge aclk); while (!s_tready);
        exp_rsp = predict_command(c);
        pending_rsp.push_back(typed ? want : exp_rsp);
        sent++;
    endtask

    task automatic drain();
        @(negedge aclk) s_tvalid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (16) @(negedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk) cfg_we <= 1'b0;
        if (idx == CFG_TOTAL_BLOCKS) m_total = val;
        else m_total = m_total;
        if (idx == CFG_WRITE_ENABLED) m_wen = val[0];
    endtask

    function automatic logic [15:0] rand_count(int nblk);
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(0, nblk * BLOCK_BYTES + 600));
            2: return 16'(BLOCK_BYTES * $urandom_range(0, nblk));
            default: return 16'(nblk * BLOCK_BYTES);
        endcase
    endfunction

    function automatic logic [7:0] rand_opcode();
        logic [7:0] ops[13] = '{OP_BOOT_READ, OP_NOP, OP_SENSE, OP_UNCOND_RSV, OP_WRITE,
            OP_READ, OP_LOCATE, OP_DEF_EXTENT, OP_READ_CHARS, OP_RELEASE, OP_READ_LOG,
            OP_RESERVE, OP_SENSE_ID};
        if ($urandom_range(0, 4) == 0) return 8'($urandom);
        return ops[$urandom_range(0, 12)];
    endfunction

    // One well-formed channel program with random content
    task automatic run_program();
        logic [31:0] base, lo, hi, span, len, fb;
        logic [7:0]  mask, lop;
        logic [7:0]  lops[5] = '{8'h01, 8'h05, 8'h06, 8'h02, 8'h04};
        int nblk, left, cnt;
        bit rd, dc;
        base = (m_total == 1) ? 0 : $urandom_range(0, m_total - 1);
        span = m_total - base;
        len = $urandom_range(0, (span - 1 < 40) ? span - 1 : 40);
        case ($urandom_range(0, 3))
            0: lo = 0;
            1: lo = 32'hFFFF_FFFF - len;
            default: lo = $urandom & 32'h7FFF_FFFF;
        endcase
        hi = lo + len;
        case ($urandom_range(0, 5))
            0: mask = 8'h00;
            1: mask = 8'h40;
            2: mask = 8'h80;
            3: mask = 8'($urandom);
            default: mask = 8'hC0;
        endcase
        send(mk(OP_DEF_EXTENT, 1, 0, 1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0) ? 16'($urandom_range(16, 40)) : 16'd16,
                {mask, 24'($urandom)}, base, lo, hi));
        repeat ($urandom_range(1, 3)) begin
            lop = ($urandom_range(0, 7) == 0) ? 8'($urandom) : lops[$urandom_range(0, 4)];
            fb = lo + $urandom_range(0, len);
            left = hi - fb + 1;
            nblk = $urandom_range(1, left < 8 ? left : 8);
            send(mk(OP_LOCATE, 0, 0, 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 4) == 0) ? 16'($urandom_range(8, 20)) : 16'd8,
                    {lop, 8'(nblk * $urandom_range(0, 3)), 16'(nblk)}, fb,
                    $urandom, $urandom));
            rd = (lop[3:0] == LOC_READ || lop[3:0] == LOC_READ_REPL);
            repeat ($urandom_range(1, 3)) begin
                dc = $urandom_range(0, 2) == 0;
                cnt = rand_count(nblk);
                send(mk(rd ? OP_READ : OP_WRITE, 0, dc, 1'($urandom_range(0, 1)),
                        16'(cnt)));
            end
        end
    endtask

    task automatic run_random(int target);
        int stop;
        stop = sent + target;
        while (sent < stop) begin
            case ($urandom_range(0, 9))
                0, 1: send(mk(rand_opcode(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              16'($urandom_range(0, 65535)),
                              $urandom, $urandom, $urandom, $urandom));
                2: begin
                    send(mk(OP_BOOT_READ, 1, $urandom_range(0, 5) == 0,
                            1'($urandom_range(0, 1)), rand_count(1)));
                    send(mk(OP_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), rand_count(2)));
                end
                default: run_program();
            endcase
        end
    endtask

    function automatic rsp_t rsp(logic [2:0] st, logic [7:0] sns, logic [15:0] resid,
                                 logic [2:0] kind = KIND_NONE, logic [5:0] rlen = 0);
        rsp_t r;
        r = '0;
        r.status = st; r.sense = sns; r.resid = resid; r.kind = kind; r.rlen = rlen;
        return r;
    endfunction

    // Compare each delivered result with the oldest outstanding one
    task automatic report(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        rsp_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result %0h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_rsp.pop_front();
                report("status", want.status, got.status);
                report("sense_out", want.sense, got.sense);
                report("residual_count", want.resid, got.resid);
                report("incorrect_length", want.il, got.il);
                report("xfer_offset", want.offset, got.offset);
                report("xfer_bytes", want.xbytes, got.xbytes);
                report("channel_bytes", want.cbytes, got.cbytes);
                report("xfer_is_read", want.is_read, got.is_read);
                report("response_kind", want.kind, got.kind);
                report("response_length", want.rlen, got.rlen);
            end
        end
    end

    // Receiver back-pressure: runs of always-ready, random, and held stalls
    int rx_len = 0, rx_mode = 0;
    always @(negedge aclk) begin
        if (rx_len == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_len = $urandom_range(4, 40);
        end
        rx_len--;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (rx_len % 9 == 0);
        endcase
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        row_t rows[$];
        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        write_cfg(CFG_TOTAL_BLOCKS, TOTAL_BLOCKS_RST);
        write_cfg(CFG_WRITE_ENABLED, 1);

        // Directed table: typed results where they are obvious
        rows.push_back('{mk(OP_NOP, 1, 0, 0, 16'hFFFF), 1, rsp(ST_DONE, 0, 16'hFFFF)});
        rows.push_back('{mk(8'h00, 0, 1, 1, 16'h1234), 1, rsp(ST_REJECT, SNS_REJECT, 16'h1234)});
        rows.push_back('{mk(8'hFF, 0, 0, 0, 0, '1, '1, '1, '1), 1,
                         rsp(ST_REJECT, SNS_REJECT, 0)});
        rows.push_back('{mk(OP_SENSE_ID, 0, 0, 0, 7), 1, rsp(ST_DONE, 0, 0, KIND_ID, 7)});
        rows.push_back('{mk(OP_READ_CHARS, 0, 0, 1, 64), 0, '0});
        rows.push_back('{mk(OP_READ_LOG, 0, 1, 0, 10), 0, '0});
        rows.push_back('{mk(OP_SENSE, 0, 0, 0, 24), 0, '0});
        rows.push_back('{mk(OP_READ, 0, 0, 0, 512), 1, rsp(ST_REJECT, SNS_REJECT, 512)});
        rows.push_back('{mk(OP_DEF_EXTENT, 1, 0, 0, 0), 1, rsp(ST_REJECT, SNS_REJECT, 0)});
        rows.push_back('{mk(OP_DEF_EXTENT, 1, 0, 0, 16, '1, '1, '1, '1), 0, '0});
        rows.push_back('{mk(OP_RESERVE, 0, 0, 0, 24), 0, '0});
        rows.push_back('{mk(OP_RELEASE, 0, 0, 0, 24), 0, '0});
        rows.push_back('{mk(OP_UNCOND_RSV, 1, 0, 0, 30), 0, '0});
        rows.push_back('{mk(OP_UNCOND_RSV, 0, 0, 0, 30), 0, '0});
        rows.push_back('{mk(OP_DEF_EXTENT, 1, 0, 0, 16, 32'hC000_0000, 10, 100, 199), 0, '0});
        rows.push_back('{mk(OP_LOCATE, 0, 0, 0, 8, 32'h0100_0004, 100), 0, '0});
        rows.push_back('{mk(OP_WRITE, 0, 1, 0, 700), 0, '0});
        rows.push_back('{mk(OP_WRITE, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk(OP_LOCATE, 0, 0, 0, 8, 32'h0200_0004, 150), 0, '0});
        rows.push_back('{mk(OP_LOCATE, 0, 0, 0, 8, 32'h0604_0002, 198), 0, '0});
        rows.push_back('{mk(OP_READ, 0, 1, 1, 300), 0, '0});
        rows.push_back('{mk(OP_READ, 0, 0, 1, 16'hFFFF), 0, '0});
        rows.push_back('{mk(OP_BOOT_READ, 1, 0, 0, 512), 0, '0});
        rows.push_back('{mk(OP_READ, 1, 0, 0, 512), 0, '0});
        rows.push_back('{mk(OP_BOOT_READ, 1, 1, 0, 512), 0, '0});
        foreach (rows[i]) send(rows[i].cmd, rows[i].typed, rows[i].want);
        drain();

        run_random(150);
        drain();
        write_cfg(CFG_TOTAL_BLOCKS, 1);
        write_cfg(CFG_WRITE_ENABLED, 0);
        run_random(100);
        drain();
        write_cfg(CFG_TOTAL_BLOCKS, 32'hFFFF_FFFF);
        write_cfg(CFG_WRITE_ENABLED, 1);
        run_random(100);
        drain();
        write_cfg(CFG_TOTAL_BLOCKS, $urandom_range(2, 1000));
        write_cfg(CFG_WRITE_ENABLED, $urandom_range(0, 1));
        run_random(100);
        drain();
        repeat (20) @(posedge aclk);

        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/fbdcu_pkg.sv
rtl/fbdcu_ctrl.sv
rtl/fbdcu_dp.sv
rtl/fixed_block_disk_command_unit.sv
rtl/fbdcu_checker.sv
tb/tb.sv
